// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 24;
  localparam int NEED_W  = SIZE_W + 1;
  localparam int BYTES_W = NEED_W + 1;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOMEM    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] base;
    logic              used;
  } tbl_entry_t;

  typedef struct packed {
    logic              en;
    logic              full;   // write size and base too, else used mark only
    logic [IDX_W-1:0]  idx;
    logic              used;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] base;
  } tbl_wr_t;

endpackage

// ===== src/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator over a table of up to MAX_BLOCKS blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_type/req_size/req_addr while busy is low; the request
//   is taken at that edge and busy stays high until the answer is out.
//   The answer shows on resp_addr/resp_status for one cycle with done high;
//   the receiver cannot stall it. busy drops in that same cycle, so the next
//   request may be started alongside done.
//   Scan: the sequencer scans the table from the newest entry to the oldest
//   through the single memory read port, one entry per cycle, through one
//   shared compare unit. A hit ends the scan with the answer. On a scan miss
//   a release answers unknown, while an allocate goes on to page rounding,
//   then to the region check and append.
//   Configuration: cfg_we/cfg_index/cfg_wdata write region_start (which also
//   reloads the bump pointer) or region_end; write only while idle.
//   Reset: clears the entry count, the bump pointer and region_end;
//   the table memory itself is not cleared, as only appended entries are read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [ffba_pkg::SIZE_W-1:0]         req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]         req_addr,
  input  logic                                cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]         cfg_wdata,
  output logic                                done,
  output logic [ffba_pkg::ADDR_W-1:0]         resp_addr,
  output logic [ffba_pkg::STAT_W-1:0]         resp_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;
  localparam logic [1:0] S_NEW  = 2'd3;

  localparam int IDX_W   = ffba_pkg::IDX_W;
  localparam int CNT_W   = ffba_pkg::CNT_W;
  localparam int ADDR_W  = ffba_pkg::ADDR_W;
  localparam int NEED_W  = ffba_pkg::NEED_W;
  localparam int BYTES_W = ffba_pkg::BYTES_W;
  localparam logic [BYTES_W-1:0] PAGE_MASK = ~(BYTES_W'(ffba_pkg::PAGE_BYTES - 1));

  logic [1:0]                  state;
  logic                        type_q;
  logic [ffba_pkg::SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0]           addr_q;
  logic [IDX_W-1:0]            cmp_idx;
  logic [CNT_W-1:0]            entry_count;
  logic [ADDR_W-1:0]           next_free_page;
  logic [ADDR_W-1:0]           region_end;
  logic [BYTES_W-1:0]          bytes_q;

  logic                  accept;
  logic                  is_rel;
  logic                  hit;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  ffba_pkg::tbl_entry_t  rd_data;
  ffba_pkg::tbl_wr_t     wr;
  logic [NEED_W-1:0]     need;
  logic [BYTES_W-1:0]    rounded;
  logic [BYTES_W-1:0]    bytes_next;
  logic [ADDR_W:0]       span;
  logic                  fits;
  logic                  room;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign is_rel = (type_q == ffba_pkg::REQ_RELEASE);
  assign cnt_m1 = entry_count - CNT_W'(1);

  // Shared compare unit: base match for release, free and large enough for allocate
  always_comb begin
    if (is_rel) begin
      hit = (rd_data.base == addr_q);
    end else begin
      hit = !rd_data.used && (rd_data.size >= ADDR_W'(size_q));
    end
  end

  always_comb begin
    rd_en  = (accept && (entry_count != '0)) ||
             ((state == S_SCAN) && !hit && (cmp_idx != '0));
    rd_idx = (state == S_IDLE) ? cnt_m1[IDX_W-1:0] : (cmp_idx - IDX_W'(1));
  end

  // Round request plus header up to whole pages, at least one page
  always_comb begin
    need    = NEED_W'(size_q) + NEED_W'(ffba_pkg::HEADER_BYTES);
    rounded = (BYTES_W'(need) + BYTES_W'(ffba_pkg::PAGE_BYTES - 1)) & PAGE_MASK;
    bytes_next = (rounded == '0) ? BYTES_W'(ffba_pkg::PAGE_BYTES) : rounded;
  end

  always_comb begin
    span = {1'b0, region_end} - {1'b0, next_free_page};
    fits = !span[ADDR_W] && (span[ADDR_W-1:0] >= ADDR_W'(bytes_q));
    room = (entry_count < CNT_W'(ffba_pkg::MAX_BLOCKS));
  end

  always_comb begin
    wr      = '0;
    wr.idx  = cmp_idx;
    wr.used = !is_rel;
    if ((state == S_SCAN) && hit) begin
      wr.en = 1'b1;
    end else if ((state == S_NEW) && fits && room) begin
      wr.en   = 1'b1;
      wr.full = 1'b1;
      wr.idx  = entry_count[IDX_W-1:0];
      wr.used = 1'b1;
      wr.base = next_free_page + ADDR_W'(ffba_pkg::HEADER_BYTES);
      wr.size = ADDR_W'(bytes_q) - ADDR_W'(ffba_pkg::HEADER_BYTES);
    end
  end

  ffba_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      entry_count    <= '0;
      next_free_page <= '0;
      region_end     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (entry_count != '0) ? S_SCAN : S_MISS;
          end
        end
        S_SCAN: begin
          if (hit) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (cmp_idx == '0) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (is_rel) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (fits && room) begin
            next_free_page <= next_free_page + ADDR_W'(bytes_q);
            entry_count    <= entry_count + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          ffba_pkg::CFG_REGION_START: begin
            next_free_page <= cfg_wdata;
          end
          ffba_pkg::CFG_REGION_END: begin
            region_end <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Request capture, scan index and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      type_q  <= req_type;
      size_q  <= req_size;
      addr_q  <= req_addr;
      cmp_idx <= cnt_m1[IDX_W-1:0];
    end else if ((state == S_SCAN) && !hit) begin
      cmp_idx <= cmp_idx - IDX_W'(1);
    end
    if (state == S_MISS) begin
      bytes_q <= bytes_next;
    end
    case (state)
      S_SCAN: begin
        resp_addr   <= rd_data.base;
        resp_status <= is_rel ? ffba_pkg::ST_RELEASED : ffba_pkg::ST_REUSED;
      end
      S_MISS: begin
        resp_addr   <= '0;
        resp_status <= ffba_pkg::ST_UNKNOWN;
      end
      S_NEW: begin
        if (fits && room) begin
          resp_addr   <= next_free_page + ADDR_W'(ffba_pkg::HEADER_BYTES);
          resp_status <= ffba_pkg::ST_NEW;
        end else begin
          resp_addr   <= '0;
          resp_status <= ffba_pkg::ST_NOMEM;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/ffba_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_table (
  input  logic                           clk,
  input  ffba_pkg::tbl_wr_t              wr,
  input  logic                           rd_en,
  input  logic [ffba_pkg::IDX_W-1:0]     rd_idx,
  output ffba_pkg::tbl_entry_t           rd_data
);

  logic [ffba_pkg::ADDR_W-1:0] size_mem [ffba_pkg::MAX_BLOCKS];
  logic [ffba_pkg::ADDR_W-1:0] base_mem [ffba_pkg::MAX_BLOCKS];
  logic                        used_mem [ffba_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      used_mem[wr.idx] <= wr.used;
      if (wr.full) begin
        size_mem[wr.idx] <= wr.size;
        base_mem[wr.idx] <= wr.base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.size <= size_mem[rd_idx];
      rd_data.base <= base_mem[rd_idx];
      rd_data.used <= used_mem[rd_idx];
    end
  end

endmodule

// ===== src/ffba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator's request and answer timing.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [ffba_pkg::ADDR_W-1:0]    resp_addr,
  input logic [ffba_pkg::STAT_W-1:0]    resp_status
);

  // A transfer always raises busy in the cycle after it
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request transfer");

  // The answer comes out as the block turns idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done || $past(rst)))
    else $error("busy dropped without an answer");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for two cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ((resp_status == ffba_pkg::ST_NOMEM) ||
              (resp_status == ffba_pkg::ST_UNKNOWN))) |-> (resp_addr == '0))
    else $error("failed request returned a nonzero address");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .resp_addr   (resp_addr),
  .resp_status (resp_status)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator.
// Directed requests walk the empty-table, region-exhaustion, reuse, duplicate
// base and extreme-size cases; random phases then mix allocate and
// release traffic over several region settings. A scoreboard keeps its own
// copy of the block table, predicts each response at the transfer and checks
// every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int ADDR_W       = ffba_pkg::ADDR_W;
  localparam int SIZE_W       = ffba_pkg::SIZE_W;
  localparam int STAT_W       = ffba_pkg::STAT_W;
  localparam int CFG_IDX_W    = ffba_pkg::CFG_IDX_W;
  localparam int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS;
  localparam int PAGE_BYTES   = ffba_pkg::PAGE_BYTES;
  localparam int HEADER_BYTES = ffba_pkg::HEADER_BYTES;
  localparam int PAGE_SHIFT   = ffba_pkg::PAGE_SHIFT;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 235;
  localparam int PAGE_PAYLOAD = PAGE_BYTES - HEADER_BYTES;
  localparam logic [SIZE_W-1:0] REQ_SIZE_MAX = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } grant_t;

  class grant_scoreboard;
    bit [ADDR_W-1:0] region_end;
    bit [ADDR_W-1:0] bump_ptr;
    bit [ADDR_W-1:0] blk_size [MAX_BLOCKS];
    bit [ADDR_W-1:0] blk_base [MAX_BLOCKS];
    bit              blk_used [MAX_BLOCKS];
    int              entries;
    grant_t          expected_grants [$];
    int              mismatches;

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      if (idx == ffba_pkg::CFG_REGION_START) begin
        bump_ptr = val;
      end else if (idx == ffba_pkg::CFG_REGION_END) begin
        region_end = val;
      end
    endfunction

    function grant_t grant_alloc(logic [SIZE_W-1:0] size);
      longint unsigned bytes;
      bit [ADDR_W-1:0] room;
      // newest entry first
      for (int k = entries - 1; k >= 0; k--) begin
        if (!blk_used[k] && blk_size[k] >= ADDR_W'(size)) begin
          blk_used[k] = 1'b1;
          return '{blk_base[k], ffba_pkg::ST_REUSED};
        end
      end
      bytes = 64'(size);
      bytes = (bytes + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
      if (bytes == 0) bytes = PAGE_BYTES;
      if (entries >= MAX_BLOCKS) return '{'0, ffba_pkg::ST_NOMEM};
      room = region_end - bump_ptr;
      if (bump_ptr > region_end || room < bytes) return '{'0, ffba_pkg::ST_NOMEM};
      blk_base[entries] = bump_ptr + ADDR_W'(HEADER_BYTES);
      blk_size[entries] = ADDR_W'(bytes - HEADER_BYTES);
      blk_used[entries] = 1'b1;
      bump_ptr = bump_ptr + ADDR_W'(bytes);
      entries++;
      return '{blk_base[entries - 1], ffba_pkg::ST_NEW};
    endfunction

    function grant_t grant_release(logic [ADDR_W-1:0] addr);
      for (int k = entries - 1; k >= 0; k--) begin
        if (blk_base[k] == addr) begin
          blk_used[k] = 1'b0;
          return '{addr, ffba_pkg::ST_RELEASED};
        end
      end
      return '{'0, ffba_pkg::ST_UNKNOWN};
    endfunction

    function void note_request(logic kind, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      if (kind == ffba_pkg::REQ_ALLOC) expected_grants.push_back(grant_alloc(size));
      else expected_grants.push_back(grant_release(addr));
    endfunction

    function void flag(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_response(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] status);
      grant_t want;
      if (expected_grants.size() == 0) begin
        flag("unrequested response, addr", '0, addr);
        return;
      end
      want = expected_grants.pop_front();
      if (addr !== want.addr) flag("resp_addr", want.addr, addr);
      if (status !== want.status) flag("resp_status", ADDR_W'(want.status), ADDR_W'(status));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 req_type;
  logic [SIZE_W-1:0]    req_size;
  logic [ADDR_W-1:0]    req_addr;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 done;
  logic [ADDR_W-1:0]    resp_addr;
  logic [STAT_W-1:0]    resp_status;

  grant_scoreboard sb = new;
  int idle_pct;
  int cycles;

  first_fit_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .req_size(req_size),
    .req_addr(req_addr),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .resp_addr(resp_addr),
    .resp_status(resp_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_response(resp_addr, resp_status);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic issue(input logic kind, input logic [SIZE_W-1:0] size,
                       input logic [ADDR_W-1:0] addr);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      // idle only once the block could take a request
      while (busy) @(negedge clk);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    req_size <= size;
    req_addr <= addr;
    // hold until the transfer
    do @(posedge clk); while (busy);
    sb.note_request(kind, size, addr);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    drain();
    write_reg(ffba_pkg::CFG_REGION_START, lo);
    write_reg(ffba_pkg::CFG_REGION_END, hi);
  endtask

  // Region kinds: 0 wide open, 1 a few aligned pages, 2 the same low pages
  // again (duplicate bases), 3 unaligned start with a random end.
  task automatic open_region(input int kind);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    longint unsigned top;
    lo = $urandom;
    case (kind)
      0: begin
        lo = $urandom_range(0, 'h7FFF) << 16;
        top = 64'hFFFF_FFFF;
      end
      1: begin
        lo[PAGE_SHIFT-1:0] = '0;
        top = 64'(lo);
        top += $urandom_range(0, 12) * PAGE_BYTES;
      end
      2: begin
        lo = ADDR_W'(PAGE_BYTES);
        top = 64'(lo);
        top += $urandom_range(1, 8) * PAGE_BYTES;
      end
      default: begin
        top = 64'(lo);
        top += $urandom_range(0, 8 * PAGE_BYTES);
        if ($urandom_range(1)) top = 64'($urandom);
      end
    endcase
    hi = (top > 64'hFFFF_FFFF) ? '1 : top[ADDR_W-1:0];
    reconfigure(lo, hi);
  endtask

  task automatic random_item(input int alloc_pct);
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    int pick;
    int k;
    // unused fields still toggle
    size = SIZE_W'($urandom);
    addr = $urandom;
    pick = $urandom_range(99);
    if ($urandom_range(99) < alloc_pct) begin
      if (pick < 45) begin
        size = SIZE_W'($urandom_range(0, PAGE_PAYLOAD));
      end else if (pick < 70) begin
        size = SIZE_W'($urandom_range(0, 3 * PAGE_BYTES));
      end else if (pick < 85 && sb.entries > 0) begin
        // land on or next to a block size boundary
        k = $urandom_range(0, sb.entries - 1);
        if (sb.blk_size[k] >= ADDR_W'(REQ_SIZE_MAX)) size = REQ_SIZE_MAX;
        else size = SIZE_W'(sb.blk_size[k] + $urandom_range(0, 2) - 1);
      end else if (pick < 95) begin
        size = SIZE_W'($urandom);
      end else begin
        case ($urandom_range(3))
          0: size = '0;
          1: size = REQ_SIZE_MAX;
          2: size = SIZE_W'(PAGE_PAYLOAD);
          default: size = SIZE_W'(PAGE_PAYLOAD + 1);
        endcase
      end
      issue(ffba_pkg::REQ_ALLOC, size, addr);
    end else begin
      if (sb.entries > 0 && pick < 75) begin
        k = $urandom_range(0, sb.entries - 1);
        addr = sb.blk_base[k];
        if (pick >= 65) addr = pick[0] ? addr + 1 : addr - 1;
      end
      issue(ffba_pkg::REQ_RELEASE, size, addr);
    end
  endtask

  initial begin
    int kind;
    rst = 1'b1;
    start = 1'b0;
    req_type = ffba_pkg::REQ_ALLOC;
    req_size = '0;
    req_addr = '0;
    cfg_we = 1'b0;
    cfg_index = ffba_pkg::CFG_REGION_START;
    cfg_wdata = '0;
    idle_pct = 30;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // region registers still at reset: nothing to carve, nothing to release
    issue(ffba_pkg::REQ_ALLOC, '0, $urandom);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), '0);

    // three pages: empty request, exact fit, one page short, exhaustion
    reconfigure(32'h0000_1000, 32'h0000_4000);
    issue(ffba_pkg::REQ_ALLOC, '0, $urandom);
    issue(ffba_pkg::REQ_ALLOC, SIZE_W'(PAGE_PAYLOAD), $urandom);
    issue(ffba_pkg::REQ_ALLOC, SIZE_W'(PAGE_PAYLOAD + 1), $urandom);
    issue(ffba_pkg::REQ_ALLOC, SIZE_W'(PAGE_PAYLOAD), $urandom);
    issue(ffba_pkg::REQ_ALLOC, '0, $urandom);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), 32'h0000_2010);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), 32'h0000_2010);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), 32'h0000_2011);
    issue(ffba_pkg::REQ_ALLOC, SIZE_W'(PAGE_PAYLOAD + 1), $urandom);
    issue(ffba_pkg::REQ_ALLOC, SIZE_W'(PAGE_PAYLOAD), $urandom);
    issue(ffba_pkg::REQ_RELEASE, REQ_SIZE_MAX, 32'hFFFF_FFFF);

    // rewind the bump pointer: duplicate base, newest match wins
    reconfigure(32'h0000_1000, 32'h0000_4000);
    issue(ffba_pkg::REQ_ALLOC, 24'd1, $urandom);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), 32'h0000_1010);
    issue(ffba_pkg::REQ_ALLOC, '0, $urandom);

    // unaligned region start
    reconfigure(32'h0000_0123, 32'h0000_3123);
    issue(ffba_pkg::REQ_ALLOC, 24'h00_1000, $urandom);

    // largest request, then reuse of that block
    reconfigure(32'h1000_0000, 32'hFFFF_FFFF);
    issue(ffba_pkg::REQ_ALLOC, REQ_SIZE_MAX, $urandom);
    issue(ffba_pkg::REQ_RELEASE, SIZE_W'($urandom), 32'h1000_0010);
    issue(ffba_pkg::REQ_ALLOC, REQ_SIZE_MAX, $urandom);

    // top of the address space, then start above end
    reconfigure(32'hFFFF_F000, 32'hFFFF_FFFF);
    issue(ffba_pkg::REQ_ALLOC, '0, $urandom);
    reconfigure(32'hFFFF_FFFF, 32'h0000_0000);
    issue(ffba_pkg::REQ_ALLOC, 24'd5, $urandom);
    issue(ffba_pkg::REQ_RELEASE, REQ_SIZE_MAX, 32'hFFFF_FFFF);

    for (int p = 0; p < 8; p++) begin
      kind = (p == 5 || p == 7) ? 0 : (p % 3) + 1;
      open_region(kind);
      idle_pct = (p == 7) ? 0 : $urandom_range(0, 2) * 25;
      repeat (PHASE_ITEMS) random_item(kind == 0 ? 75 : 60);
    end

    drain();
    repeat (MAX_BLOCKS + 8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
